### rtl/kca_pkg.sv
// ----------------------------------------------------------------------------
// kca_pkg
// Shared types and codes for the keypad cursor accelerator.
// ----------------------------------------------------------------------------
package kca_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned SPEED_BITS = 12;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned DELAY_BITS = 10;

  localparam logic signed [SPEED_BITS-1:0] SPEED_MAX  = 12'sd2047;
  localparam logic signed [SPEED_BITS-1:0] SPEED_FAST = 12'sd5;
  localparam logic signed [SPEED_BITS-1:0] SPEED_ONE  = 12'sd1;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_PRESS   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [3:0] KEY_UP        = 4'd0;
  localparam logic [3:0] KEY_DOWN      = 4'd1;
  localparam logic [3:0] KEY_LEFT      = 4'd2;
  localparam logic [3:0] KEY_RIGHT     = 4'd3;
  localparam logic [3:0] KEY_PRIMARY   = 4'd4;
  localparam logic [3:0] KEY_SECONDARY = 4'd5;
  localparam logic [3:0] KEY_POWER     = 4'd6;
  localparam logic [3:0] KEY_FKEY_A    = 4'd7;
  localparam logic [3:0] KEY_FKEY_B    = 4'd8;

  localparam logic [2:0] EV_MOVE    = 3'd0;
  localparam logic [2:0] EV_LDOWN   = 3'd1;
  localparam logic [2:0] EV_LUP     = 3'd2;
  localparam logic [2:0] EV_RDOWN   = 3'd3;
  localparam logic [2:0] EV_RUP     = 3'd4;
  localparam logic [2:0] EV_QUIT    = 3'd5;
  localparam logic [2:0] EV_KEYDOWN = 3'd6;
  localparam logic [2:0] EV_KEYUP   = 3'd7;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ARMED  = 2'd1;
  localparam logic [1:0] PH_TIMING = 2'd2;

  localparam logic [1:0] REG_STEP_DELAY = 2'd0;
  localparam logic [1:0] REG_X_LIMIT    = 2'd1;
  localparam logic [1:0] REG_Y_LIMIT    = 2'd2;

  typedef struct packed {
    logic [SPEED_BITS-1:0] speed;
    logic [1:0]            phase;
    logic [COORD_BITS-1:0] pos;
  } axis_t;

endpackage

### rtl/kca_axis.sv
// ----------------------------------------------------------------------------
// kca_axis
// Acceleration, move and edge clamp of one cursor axis on a due tick.
// ----------------------------------------------------------------------------
module kca_axis (
  input  kca_pkg::axis_t                     st_i,
  input  logic [kca_pkg::TIME_BITS-1:0]      start_i,
  input  logic [kca_pkg::TIME_BITS-1:0]      now_i,
  input  logic [kca_pkg::DELAY_BITS-1:0]     delay_i,
  input  logic [kca_pkg::COORD_BITS-1:0]     limit_i,
  output kca_pkg::axis_t                     st_o
);
  import kca_pkg::*;

  logic [DELAY_BITS+3:0]         d12;
  logic [DELAY_BITS+2:0]         d8;
  logic [TIME_BITS-1:0]          t12;
  logic [TIME_BITS-1:0]          t8;
  logic signed [SPEED_BITS-1:0]  spd;
  logic signed [SPEED_BITS-1:0]  acc;
  logic signed [COORD_BITS+1:0]  sum;
  logic signed [COORD_BITS+1:0]  lim;

  assign d12 = {1'b0, delay_i, 3'b000} + {2'b00, delay_i, 2'b00};
  assign d8  = {delay_i, 3'b000};
  assign t12 = start_i + {{(TIME_BITS-DELAY_BITS-4){1'b0}}, d12};
  assign t8  = start_i + {{(TIME_BITS-DELAY_BITS-3){1'b0}}, d8};
  assign spd = $signed(st_i.speed);

  always_comb begin
    acc = spd;
    if (st_i.phase != PH_IDLE) begin
      if (now_i > t12) begin
        if (spd > 0) begin
          acc = (spd < SPEED_MAX) ? spd + SPEED_ONE : SPEED_MAX;
        end else begin
          acc = (spd > -SPEED_MAX) ? spd - SPEED_ONE : -SPEED_MAX;
        end
      end else if (now_i > t8) begin
        acc = (spd > 0) ? SPEED_FAST : -SPEED_FAST;
      end
    end
  end

  assign sum = {{2{acc[SPEED_BITS-1]}}, acc} + $signed({2'b00, st_i.pos});
  assign lim = $signed({2'b00, limit_i});

  always_comb begin
    st_o.speed = acc;
    st_o.phase = st_i.phase;
    st_o.pos   = sum[COORD_BITS-1:0];
    if (sum < 0) begin
      st_o.pos   = '0;
      st_o.speed = -SPEED_ONE;
      st_o.phase = PH_ARMED;
    end else if (sum > lim) begin
      st_o.pos   = limit_i;
      st_o.speed = SPEED_ONE;
      st_o.phase = PH_ARMED;
    end
  end

endmodule

### rtl/keypad_cursor_accelerator.sv
// ----------------------------------------------------------------------------
// keypad_cursor_accelerator
// Turns arrow-key presses and millisecond ticks into cursor events with
// hold acceleration, and maps the other keys to button and key events.
// ----------------------------------------------------------------------------
//   channel | signals                                        | direction
//   cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | in
//   in      | in_valid_i in_ready_o opcode_i now_ms_i key_i  | in
//   out     | out_valid_o out_ready_i event_kind_o x_pos_o   | out
//           | y_pos_o key_id_o                               |
//
// An accepted word is held in the input register, and the axis logic loads its
// result into the result register when the word leaves the input register.
// A new word is accepted every cycle while the result register drains.
// The input stalls only while a word with a result waits behind an unaccepted one.
// Reset clears all cursor state and loads the default register values.
// The configuration port is always ready and takes one write per cycle.
// ----------------------------------------------------------------------------
module keypad_cursor_accelerator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_index_i,
  input  logic [11:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        opcode_i,
  input  logic [kca_pkg::TIME_BITS-1:0]     now_ms_i,
  input  logic [3:0]                        key_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        event_kind_o,
  output logic [kca_pkg::COORD_BITS-1:0]    x_pos_o,
  output logic [kca_pkg::COORD_BITS-1:0]    y_pos_o,
  output logic                              key_id_o
);
  import kca_pkg::*;

  logic [DELAY_BITS-1:0] delay_q;
  logic [COORD_BITS-1:0] x_lim_q, y_lim_q;

  logic                  in_vld_q;
  logic [1:0]            op_q;
  logic [TIME_BITS-1:0]  now_q;
  logic [3:0]            key_q;

  logic [TIME_BITS-1:0]  last_q, last_d;
  logic [TIME_BITS-1:0]  x_start_q, x_start_d, y_start_q, y_start_d;
  axis_t                 x_q, x_d, y_q, y_d;
  axis_t                 x_eff, y_eff, x_new, y_new;

  logic                  out_vld_q;
  logic [2:0]            kind_q, kind_d;
  logic [COORD_BITS-1:0] xo_q, xo_d, yo_q, yo_d;
  logic                  id_q, id_d;

  logic                  has_res;
  logic                  adv;
  logic                  press;
  logic                  due;
  logic [TIME_BITS-1:0]  due_at;

  assign press  = (op_q == OP_PRESS);
  assign due_at = last_q + {{(TIME_BITS-DELAY_BITS){1'b0}}, delay_q};
  assign due    = !(now_q < due_at);

  always_comb begin
    x_eff = x_q;
    y_eff = y_q;
    if (x_q.phase == PH_ARMED) begin
      x_eff.phase = PH_TIMING;
    end
    if (y_q.phase == PH_ARMED) begin
      y_eff.phase = PH_TIMING;
    end
  end

  assign x_start_d = (op_q == OP_TICK && due && x_q.phase == PH_ARMED) ? now_q : x_start_q;
  assign y_start_d = (op_q == OP_TICK && due && y_q.phase == PH_ARMED) ? now_q : y_start_q;

  kca_axis u_x_axis (
    .st_i    (x_eff),
    .start_i (x_start_d),
    .now_i   (now_q),
    .delay_i (delay_q),
    .limit_i (x_lim_q),
    .st_o    (x_new)
  );

  kca_axis u_y_axis (
    .st_i    (y_eff),
    .start_i (y_start_d),
    .now_i   (now_q),
    .delay_i (delay_q),
    .limit_i (y_lim_q),
    .st_o    (y_new)
  );

  always_comb begin
    has_res = 1'b0;
    last_d  = last_q;
    x_d     = x_q;
    y_d     = y_q;
    kind_d  = EV_MOVE;
    xo_d    = x_q.pos;
    yo_d    = y_q.pos;
    id_d    = 1'b0;
    if (op_q == OP_TICK) begin
      if (due) begin
        last_d = now_q;
        if (x_q.speed == '0 && y_q.speed == '0) begin
          x_d = x_eff;
          y_d = y_eff;
        end else begin
          x_d     = x_new;
          y_d     = y_new;
          xo_d    = x_new.pos;
          yo_d    = y_new.pos;
          has_res = 1'b1;
        end
      end
    end else if (op_q == OP_PRESS || op_q == OP_RELEASE) begin
      unique case (key_q) inside
        KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT: begin
          has_res = 1'b1;
          if (press) begin
            if (key_q == KEY_UP || key_q == KEY_DOWN) begin
              y_d.speed = (key_q == KEY_UP) ? -SPEED_ONE : SPEED_ONE;
              y_d.phase = PH_ARMED;
            end else begin
              x_d.speed = (key_q == KEY_LEFT) ? -SPEED_ONE : SPEED_ONE;
              x_d.phase = PH_ARMED;
            end
          end else begin
            x_d.speed = '0;
            y_d.speed = '0;
            x_d.phase = PH_IDLE;
            y_d.phase = PH_IDLE;
          end
        end
        KEY_PRIMARY: begin
          has_res = 1'b1;
          kind_d  = press ? EV_LDOWN : EV_LUP;
        end
        KEY_SECONDARY: begin
          has_res = 1'b1;
          kind_d  = press ? EV_RDOWN : EV_RUP;
        end
        KEY_POWER: begin
          has_res = 1'b1;
          kind_d  = EV_QUIT;
          xo_d    = '0;
          yo_d    = '0;
        end
        KEY_FKEY_A, KEY_FKEY_B: begin
          has_res = 1'b1;
          kind_d  = press ? EV_KEYDOWN : EV_KEYUP;
          xo_d    = '0;
          yo_d    = '0;
          id_d    = (key_q == KEY_FKEY_B);
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end
  end

  assign adv        = in_vld_q && (!has_res || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_BITS'(25);
      x_lim_q <= COORD_BITS'(319);
      y_lim_q <= COORD_BITS'(199);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STEP_DELAY: delay_q <= cfg_data_i[DELAY_BITS-1:0];
        REG_X_LIMIT:    x_lim_q <= cfg_data_i[COORD_BITS-1:0];
        REG_Y_LIMIT:    y_lim_q <= cfg_data_i[COORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q  <= opcode_i;
      now_q <= now_ms_i;
      key_q <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      x_start_q <= '0;
      y_start_q <= '0;
      x_q       <= '0;
      y_q       <= '0;
    end else if (adv) begin
      last_q    <= last_d;
      x_start_q <= x_start_d;
      y_start_q <= y_start_d;
      x_q       <= x_d;
      y_q       <= y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && has_res) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && has_res) begin
      kind_q <= kind_d;
      xo_q   <= xo_d;
      yo_q   <= yo_d;
      id_q   <= id_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign event_kind_o = kind_q;
  assign x_pos_o      = xo_q;
  assign y_pos_o      = yo_q;
  assign key_id_o     = id_q;

`ifndef SYNTHESIS
  a_x_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_q.speed != {1'b1, {(SPEED_BITS-1){1'b0}}})
    else $error("x speed beyond limit");

  a_y_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    y_q.speed != {1'b1, {(SPEED_BITS-1){1'b0}}})
    else $error("y speed beyond limit");

  a_x_still_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_q.speed == '0) |-> (x_q.phase == PH_IDLE))
    else $error("x axis stopped but hold timer running");

  a_y_still_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (y_q.speed == '0) |-> (y_q.phase == PH_IDLE))
    else $error("y axis stopped but hold timer running");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q))
    else $error("input stalled without a pending result");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q))
    else $error("result appeared without a word in the input register");
`endif

endmodule

### verif/keypad_cursor_accelerator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_cursor_accelerator_tb
// Drives key presses, releases and millisecond ticks into the cursor
// accelerator and checks every event word against a cycle-free prediction
// of hold acceleration, edge clamping and key mapping. A directed opening
// is followed by random gestures and noise under several register settings,
// with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module keypad_cursor_accelerator_tb;
  import kca_pkg::*;

  localparam logic [1:0] OP_NONE    = 2'd3;
  localparam logic [3:0] KEY_OTHER  = 4'd9;
  localparam logic [3:0] KEY_UNUSED = 4'd15;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int unsigned RANDOM_WORDS   = 1600;
  localparam int unsigned PHASE_WORDS    = 220;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [2:0]            kind;
    logic [COORD_BITS-1:0] x_pos;
    logic [COORD_BITS-1:0] y_pos;
    logic                  key_id;
  } cursor_event_t;

  class cursor_scoreboard;
    logic [DELAY_BITS-1:0]        step_delay;
    logic [COORD_BITS-1:0]        x_limit;
    logic [COORD_BITS-1:0]        y_limit;
    logic [TIME_BITS-1:0]         last_update;
    logic [TIME_BITS-1:0]         x_hold_start;
    logic [TIME_BITS-1:0]         y_hold_start;
    logic [1:0]                   x_phase;
    logic [1:0]                   y_phase;
    logic signed [SPEED_BITS-1:0] x_speed;
    logic signed [SPEED_BITS-1:0] y_speed;
    logic [COORD_BITS-1:0]        cur_x;
    logic [COORD_BITS-1:0]        cur_y;
    cursor_event_t                expected_events[$];
    int unsigned                  errors;

    function new();
      step_delay   = 10'd25;
      x_limit      = 12'd319;
      y_limit      = 12'd199;
      last_update  = '0;
      x_hold_start = '0;
      y_hold_start = '0;
      x_phase      = PH_IDLE;
      y_phase      = PH_IDLE;
      x_speed      = '0;
      y_speed      = '0;
      cur_x        = '0;
      cur_y        = '0;
      errors       = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [11:0] data);
      case (index)
        REG_STEP_DELAY: step_delay = data[DELAY_BITS-1:0];
        REG_X_LIMIT:    x_limit = data;
        REG_Y_LIMIT:    y_limit = data;
        default: ;
      endcase
    endfunction

    function logic signed [SPEED_BITS-1:0] accelerate(logic signed [SPEED_BITS-1:0] speed,
                                                      logic [1:0] phase,
                                                      logic [TIME_BITS-1:0] start,
                                                      logic [TIME_BITS-1:0] now);
      logic [TIME_BITS-1:0] ramp_at;
      logic [TIME_BITS-1:0] fast_at;
      if (phase == PH_IDLE) return speed;
      ramp_at = start + 32'(step_delay) * 32'd12;
      fast_at = start + 32'(step_delay) * 32'd8;
      if (now > ramp_at) begin
        if (speed > 0) return (speed < SPEED_MAX) ? speed + SPEED_ONE : SPEED_MAX;
        return (speed > -SPEED_MAX) ? speed - SPEED_ONE : -SPEED_MAX;
      end
      if (now > fast_at) return (speed > 0) ? SPEED_FAST : -SPEED_FAST;
      return speed;
    endfunction

    function void move_axis(inout logic [COORD_BITS-1:0] pos,
                            inout logic signed [SPEED_BITS-1:0] speed,
                            inout logic [1:0] phase,
                            input logic [COORD_BITS-1:0] limit);
      int target;
      target = int'(pos) + int'(speed);
      if (target < 0) begin
        pos   = '0;
        speed = -SPEED_ONE;
        phase = PH_ARMED;
      end else if (target > int'(limit)) begin
        pos   = limit;
        speed = SPEED_ONE;
        phase = PH_ARMED;
      end else begin
        pos = target[COORD_BITS-1:0];
      end
    endfunction

    function void queue_event(logic [2:0] kind, logic [COORD_BITS-1:0] x,
                              logic [COORD_BITS-1:0] y, logic id);
      expected_events.push_back('{kind, x, y, id});
    endfunction

    function void note_word(logic [1:0] op, logic [TIME_BITS-1:0] now, logic [3:0] key);
      logic press;
      press = (op == OP_PRESS);
      if (op == OP_TICK) begin
        if (now < last_update + 32'(step_delay)) return;
        last_update = now;
        if (x_phase == PH_ARMED) begin
          x_hold_start = now;
          x_phase      = PH_TIMING;
        end
        if (y_phase == PH_ARMED) begin
          y_hold_start = now;
          y_phase      = PH_TIMING;
        end
        if (x_speed == 0 && y_speed == 0) return;
        x_speed = accelerate(x_speed, x_phase, x_hold_start, now);
        y_speed = accelerate(y_speed, y_phase, y_hold_start, now);
        move_axis(cur_x, x_speed, x_phase, x_limit);
        move_axis(cur_y, y_speed, y_phase, y_limit);
        queue_event(EV_MOVE, cur_x, cur_y, 1'b0);
        return;
      end
      if (op == OP_NONE) return;
      case (key)
        KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT: begin
          if (!press) begin
            x_speed = '0;
            y_speed = '0;
            x_phase = PH_IDLE;
            y_phase = PH_IDLE;
          end else if (key == KEY_UP || key == KEY_DOWN) begin
            y_speed = (key == KEY_UP) ? -SPEED_ONE : SPEED_ONE;
            y_phase = PH_ARMED;
          end else begin
            x_speed = (key == KEY_LEFT) ? -SPEED_ONE : SPEED_ONE;
            x_phase = PH_ARMED;
          end
          queue_event(EV_MOVE, cur_x, cur_y, 1'b0);
        end
        KEY_PRIMARY:   queue_event(press ? EV_LDOWN : EV_LUP, cur_x, cur_y, 1'b0);
        KEY_SECONDARY: queue_event(press ? EV_RDOWN : EV_RUP, cur_x, cur_y, 1'b0);
        KEY_POWER:     queue_event(EV_QUIT, '0, '0, 1'b0);
        KEY_FKEY_A, KEY_FKEY_B: begin
          queue_event(press ? EV_KEYDOWN : EV_KEYUP, '0, '0, key == KEY_FKEY_B);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_event(logic [2:0] kind, logic [COORD_BITS-1:0] x,
                              logic [COORD_BITS-1:0] y, logic id);
      cursor_event_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind %0d at (%0d,%0d) id %0d",
                 $time, kind, x, y, id);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      compare_field("event_kind", want.kind, kind);
      compare_field("x_pos", want.x_pos, x);
      compare_field("y_pos", want.y_pos, y);
      compare_field("key_id", want.key_id, id);
    endfunction
  endclass

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i  = REG_STEP_DELAY;
  logic [11:0]           cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            opcode_i     = OP_TICK;
  logic [TIME_BITS-1:0]  now_ms_i     = '0;
  logic [3:0]            key_i        = KEY_UP;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b1;
  logic [2:0]            event_kind_o;
  logic [COORD_BITS-1:0] x_pos_o;
  logic [COORD_BITS-1:0] y_pos_o;
  logic                  key_id_o;

  cursor_scoreboard     sb = new();
  int unsigned          idle_cycles = 0;
  int unsigned          words_sent  = 0;
  int unsigned          burst_left  = 0;
  logic [TIME_BITS-1:0] clock_ms    = '0;
  logic [15:0]          ready_mask  = 16'hFFFF;
  int unsigned          ready_step  = 0;

  keypad_cursor_accelerator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .now_ms_i    (now_ms_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .event_kind_o(event_kind_o),
    .x_pos_o     (x_pos_o),
    .y_pos_o     (y_pos_o),
    .key_id_o    (key_id_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    ready_step++;
    if (ready_step % 48 == 0) begin
      ready_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
    out_ready_i <= ready_mask[ready_step % 16];
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_event(event_kind_o, x_pos_o, y_pos_o, key_id_o);
      if (in_valid_i && in_ready_o) sb.note_word(opcode_i, now_ms_i, key_i);
      if (cfg_valid_i && cfg_ready_o) sb.set_register(cfg_index_i, cfg_data_i);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_word(input logic [1:0] op, input logic [TIME_BITS-1:0] now,
                           input logic [3:0] key);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    now_ms_i   <= now;
    key_i      <= key;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic tick_at(input logic [TIME_BITS-1:0] now);
    send_word(OP_TICK, now, 4'($urandom));
  endtask

  task automatic key_word(input logic [1:0] op, input logic [3:0] key);
    send_word(op, $urandom, key);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [11:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_events.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    burst_left = $urandom_range(0, 20);
  endtask

  task automatic program_phase(input int unsigned phase);
    logic [DELAY_BITS-1:0] delay;
    logic [11:0]           xl;
    logic [11:0]           yl;
    case (phase % 6)
      0: begin delay = 10'd1;    xl = 12'd0;    yl = 12'd0;    end
      1: begin delay = 10'd1000; xl = 12'd4095; yl = 12'd4095; end
      2: begin delay = 10'd5;    xl = 12'd4095; yl = 12'd0;    end
      3: begin delay = 10'd1000; xl = 12'd0;    yl = 12'd4095; end
      4: begin delay = 10'd25;   xl = 12'd319;  yl = 12'd199;  end
      default: begin
        delay = 10'($urandom_range(1, 1000));
        xl    = 12'($urandom);
        yl    = 12'($urandom);
      end
    endcase
    write_register(REG_X_LIMIT, xl);
    write_register(REG_STEP_DELAY, {2'($urandom), delay});
    if (phase % 6 == 1) write_register(REG_UNUSED, 12'($urandom));
    write_register(REG_Y_LIMIT, yl);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_gesture();
    logic [TIME_BITS-1:0] span;
    logic [TIME_BITS-1:0] advance;
    clock_ms = sb.last_update;
    span     = 32'(sb.step_delay);
    case ($urandom_range(0, 2))
      0: key_word(OP_PRESS, $urandom_range(0, 1) ? KEY_RIGHT : KEY_LEFT);
      1: key_word(OP_PRESS, $urandom_range(0, 1) ? KEY_DOWN : KEY_UP);
      default: begin
        key_word(OP_PRESS, $urandom_range(0, 1) ? KEY_RIGHT : KEY_LEFT);
        key_word(OP_PRESS, $urandom_range(0, 1) ? KEY_DOWN : KEY_UP);
      end
    endcase
    repeat ($urandom_range(1, 32)) begin
      if ($urandom_range(0, 15) == 0) key_word(OP_PRESS, 4'($urandom_range(KEY_UP, KEY_RIGHT)));
      case ($urandom_range(0, 9))
        0:       advance = $urandom_range(0, span - 1);
        1:       advance = span * $urandom_range(2, 14);
        default: advance = span + $urandom_range(0, span / 2);
      endcase
      clock_ms += advance;
      tick_at(clock_ms);
    end
    if ($urandom_range(0, 5) != 0) key_word(OP_RELEASE, 4'($urandom_range(KEY_UP, KEY_RIGHT)));
  endtask

  task automatic run_button();
    logic [3:0] button;
    button = 4'($urandom_range(KEY_PRIMARY, KEY_OTHER));
    key_word(OP_PRESS, button);
    if ($urandom_range(0, 1) != 0) tick_at(sb.last_update + 32'(sb.step_delay));
    key_word(OP_RELEASE, button);
  endtask

  task automatic run_activity();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      run_gesture();
    end else if (pick < 8) begin
      run_button();
    end else begin
      repeat ($urandom_range(1, 4)) send_word(2'($urandom), $urandom, 4'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_start;
    int unsigned random_start;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    key_word(OP_PRESS, KEY_RIGHT);
    tick_at(32'd25);
    tick_at(32'd30);
    tick_at(32'd250);
    tick_at(32'd350);
    key_word(OP_PRESS, KEY_DOWN);
    key_word(OP_PRESS, KEY_LEFT);
    tick_at(32'd400);
    key_word(OP_PRESS, KEY_UP);
    tick_at(32'd430);
    tick_at(32'd460);
    key_word(OP_RELEASE, KEY_UP);
    tick_at(32'd500);
    key_word(OP_PRESS, KEY_PRIMARY);
    key_word(OP_RELEASE, KEY_PRIMARY);
    key_word(OP_PRESS, KEY_SECONDARY);
    key_word(OP_RELEASE, KEY_SECONDARY);
    key_word(OP_PRESS, KEY_POWER);
    key_word(OP_RELEASE, KEY_POWER);
    key_word(OP_PRESS, KEY_FKEY_A);
    key_word(OP_RELEASE, KEY_FKEY_A);
    key_word(OP_PRESS, KEY_FKEY_B);
    key_word(OP_RELEASE, KEY_FKEY_B);
    key_word(OP_PRESS, KEY_OTHER);
    key_word(OP_RELEASE, KEY_UNUSED);
    send_word(OP_NONE, 32'hFFFF_FFFF, KEY_RIGHT);
    key_word(OP_PRESS, KEY_RIGHT);
    tick_at(32'hFFFF_FFF0);
    tick_at(32'h0000_0005);
    tick_at(32'h0000_0010);
    key_word(OP_RELEASE, KEY_RIGHT);

    random_start = words_sent;
    phase = 0;
    while (words_sent - random_start < RANDOM_WORDS) begin
      drain_results();
      program_phase(phase);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) run_activity();
      phase++;
    end
    drain_results();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
